/* src/stacked_sorted_rows_search_macros.svh */
// Assertion macros for the stacked sorted rows search block.
// Used by stacked_sorted_rows_search.sv; no other dependencies.
`ifndef STACKED_SORTED_ROWS_SEARCH_MACROS_SVH
`define STACKED_SORTED_ROWS_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SSRS_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("invariant violated");
`define SSRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SSRS_ASSERT_ALWAYS(label, clk, rstn, expr)
`define SSRS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* src/ssrs_pkg.sv */
// Shared types and constants for the stacked sorted rows search block.
// No dependencies.
package ssrs_pkg;

    localparam int VALUE_WIDTH      = 32;
    localparam int MAX_ROWS_DEF     = 16;
    localparam int MAX_ELEMENTS_DEF = 256;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FOUND = 2'd1;
    localparam logic [1:0] STAT_MISS  = 2'd2;
    localparam logic [1:0] STAT_OVER  = 2'd3;

    typedef struct packed {
        logic [1:0]                    action;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last_in_row;
    } ssrs_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] position;
        logic [3:0] rows_below;
    } ssrs_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_RD,
        S_ROW_INIT,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_DONE
    } ssrs_state_t;

    typedef struct packed {
        logic init;
        logic issue;
        logic step;
    } ssrs_probe_ctl_t;

    typedef struct packed {
        logic live;
        logic hit;
    } ssrs_probe_sts_t;

endpackage

/* src/ssrs_probe.sv */
// Binary search bounds and midpoint for one row of the stacked sorted rows search.
// Depends on ssrs_pkg.
module ssrs_probe #(
    parameter int CW = 9
) (
    input  logic                                    aclk,
    input  ssrs_pkg::ssrs_probe_ctl_t               ctl,
    input  logic [CW-1:0]                           row_len,
    input  logic signed [ssrs_pkg::VALUE_WIDTH-1:0] elem_data,
    input  logic signed [ssrs_pkg::VALUE_WIDTH-1:0] key,
    output logic [CW-1:0]                           mid,
    output logic [CW-1:0]                           mid_reg,
    output ssrs_pkg::ssrs_probe_sts_t               sts
);

    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hp_reg;
    logic [CW:0]   span_sum;

    assign span_sum = {1'b0, lo_reg} + {1'b0, hp_reg} - {{CW{1'b0}}, 1'b1};
    assign mid      = span_sum[CW:1];
    assign sts.live = lo_reg < hp_reg;
    assign sts.hit  = elem_data == key;

    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            lo_reg <= '0;
            hp_reg <= row_len;
        end else if (ctl.step) begin
            if (elem_data > key) begin
                hp_reg <= mid_reg;
            end else if (elem_data < key) begin
                lo_reg <= mid_reg + CW'(1);
            end
        end
        if (ctl.issue) begin
            mid_reg <= mid;
        end
    end

endmodule

/* src/stacked_sorted_rows_search.sv */
// Load, load-last and clear items: result registered at accept.
// Query: accept, then per searched row a row table read and bound init,
// then one element memory read and compare per probe (the row that
// matches stops at the hit), then the result is presented. One item at a time.
// Reset (aresetn low, synchronous): store empty, output empty; memories are not cleared.
`include "stacked_sorted_rows_search_macros.svh"
module stacked_sorted_rows_search #(
    parameter int MAX_ROWS     = ssrs_pkg::MAX_ROWS_DEF,
    parameter int MAX_ELEMENTS = ssrs_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssrs_pkg::ssrs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssrs_pkg::ssrs_out_t m_data
);

    localparam int VW = ssrs_pkg::VALUE_WIDTH;
    localparam int EA = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RC = $clog2(MAX_ROWS + 1);
    localparam int RW = EA + CW;

    logic signed [VW-1:0] elem_mem [MAX_ELEMENTS];
    logic [RW-1:0]        row_mem  [MAX_ROWS];

    ssrs_pkg::ssrs_state_t state_reg, state_next;

    logic [CW-1:0]        fill_count_reg;
    logic [CW-1:0]        open_len_reg;
    logic [CW-1:0]        open_start_reg;
    logic [RC-1:0]        row_count_reg;
    logic signed [VW-1:0] key_reg;
    logic [RA-1:0]        r_reg;
    ssrs_pkg::ssrs_out_t  res_reg;
    logic                 m_valid_reg;
    ssrs_pkg::ssrs_out_t  m_data_reg;
    logic [RW-1:0]        row_rd_reg;
    logic signed [VW-1:0] elem_rd_reg;

    logic                 accept;
    logic                 out_free;
    logic                 load_ok;
    logic                 is_query;
    logic                 rows_empty;
    logic                 out_load;
    ssrs_pkg::ssrs_out_t  out_next;
    logic                 elem_we;
    logic                 row_we;
    logic [EA-1:0]        elem_rd_addr;
    logic [EA-1:0]        row_start;
    logic [CW-1:0]        row_len;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        mid_reg;
    logic [CW-1:0]        probe_addr;

    ssrs_pkg::ssrs_probe_ctl_t probe_ctl;
    ssrs_pkg::ssrs_probe_sts_t probe_sts;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ssrs_pkg::S_IDLE) && out_free;
    assign accept     = s_valid && s_ready;
    assign is_query   = s_data.action == ssrs_pkg::ACT_QUERY;
    assign rows_empty = row_count_reg == '0;
    assign load_ok    = (fill_count_reg != CW'(MAX_ELEMENTS))
                     && (row_count_reg != RC'(MAX_ROWS));
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    assign row_start    = row_rd_reg[RW-1:CW];
    assign row_len      = row_rd_reg[CW-1:0];
    assign probe_addr   = {{(CW-EA){1'b0}}, row_start} + mid;
    assign elem_rd_addr = probe_addr[EA-1:0];

    ssrs_probe #(
        .CW(CW)
    ) u_probe (
        .aclk     (aclk),
        .ctl      (probe_ctl),
        .row_len  (row_len),
        .elem_data(elem_rd_reg),
        .key      (key_reg),
        .mid      (mid),
        .mid_reg  (mid_reg),
        .sts      (probe_sts)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssrs_pkg::S_IDLE: begin
                if (accept && is_query && !rows_empty) begin
                    state_next = ssrs_pkg::S_ROW_RD;
                end
            end
            ssrs_pkg::S_ROW_RD: begin
                state_next = ssrs_pkg::S_ROW_INIT;
            end
            ssrs_pkg::S_ROW_INIT: begin
                state_next = ssrs_pkg::S_PROBE_RD;
            end
            ssrs_pkg::S_PROBE_RD: begin
                if (probe_sts.live) begin
                    state_next = ssrs_pkg::S_PROBE_CMP;
                end else if (r_reg == '0) begin
                    state_next = ssrs_pkg::S_DONE;
                end else begin
                    state_next = ssrs_pkg::S_ROW_RD;
                end
            end
            ssrs_pkg::S_PROBE_CMP: begin
                if (probe_sts.hit) begin
                    state_next = ssrs_pkg::S_DONE;
                end else begin
                    state_next = ssrs_pkg::S_PROBE_RD;
                end
            end
            ssrs_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = ssrs_pkg::S_IDLE;
                end
            end
            default: state_next = ssrs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        probe_ctl.init  = state_reg == ssrs_pkg::S_ROW_INIT;
        probe_ctl.issue = state_reg == ssrs_pkg::S_PROBE_RD;
        probe_ctl.step  = state_reg == ssrs_pkg::S_PROBE_CMP;
        elem_we  = 1'b0;
        row_we   = 1'b0;
        out_load = 1'b0;
        out_next = '0;
        if (state_reg == ssrs_pkg::S_DONE) begin
            out_load = out_free;
            out_next = res_reg;
        end else if (accept) begin
            case (s_data.action)
                ssrs_pkg::ACT_LOAD: begin
                    out_load = 1'b1;
                    if (load_ok) begin
                        elem_we         = 1'b1;
                        row_we          = s_data.last_in_row;
                        out_next.status = ssrs_pkg::STAT_OK;
                    end else begin
                        out_next.status = ssrs_pkg::STAT_OVER;
                    end
                end
                ssrs_pkg::ACT_QUERY: begin
                    out_load        = rows_empty;
                    out_next.status = ssrs_pkg::STAT_MISS;
                end
                default: begin
                    out_load        = 1'b1;
                    out_next.status = ssrs_pkg::STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[fill_count_reg[EA-1:0]] <= s_data.value;
        end
        elem_rd_reg <= elem_mem[elem_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_count_reg[RA-1:0]] <= {open_start_reg[EA-1:0], open_len_reg + CW'(1)};
        end
        row_rd_reg <= row_mem[r_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ssrs_pkg::S_IDLE;
            fill_count_reg <= '0;
            open_len_reg   <= '0;
            open_start_reg <= '0;
            row_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (elem_we) begin
                fill_count_reg <= fill_count_reg + CW'(1);
                if (row_we) begin
                    row_count_reg  <= row_count_reg + RC'(1);
                    open_len_reg   <= '0;
                    open_start_reg <= fill_count_reg + CW'(1);
                end else begin
                    open_len_reg <= open_len_reg + CW'(1);
                end
            end else if (accept && s_data.action == ssrs_pkg::ACT_CLEAR) begin
                fill_count_reg <= '0;
                open_len_reg   <= '0;
                open_start_reg <= '0;
                row_count_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_next;
        end
        if (accept && is_query) begin
            key_reg <= s_data.value;
            r_reg   <= RA'(row_count_reg - RC'(1));
        end
        if (state_reg == ssrs_pkg::S_PROBE_RD && !probe_sts.live) begin
            if (r_reg == '0) begin
                res_reg.status     <= ssrs_pkg::STAT_MISS;
                res_reg.position   <= '0;
                res_reg.rows_below <= '0;
            end else begin
                r_reg <= r_reg - RA'(1);
            end
        end
        if (state_reg == ssrs_pkg::S_PROBE_CMP && probe_sts.hit) begin
            res_reg.status     <= ssrs_pkg::STAT_FOUND;
            res_reg.position   <= 8'(mid_reg);
            res_reg.rows_below <= 4'(r_reg);
        end
    end

    `SSRS_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_count_reg <= CW'(MAX_ELEMENTS))
    `SSRS_ASSERT_ALWAYS(a_rows_bound, aclk, aresetn, row_count_reg <= RC'(MAX_ROWS))
    `SSRS_ASSERT_ALWAYS(a_open_in_fill, aclk, aresetn, open_len_reg <= fill_count_reg)
    `SSRS_ASSERT_ALWAYS(a_open_span, aclk, aresetn, open_start_reg + open_len_reg == fill_count_reg)
    `SSRS_ASSERT_NEXT(a_store_frozen, aclk, aresetn, state_reg != ssrs_pkg::S_IDLE, $stable(fill_count_reg))

endmodule
